/* src/rss_pkg.sv */
// Shared types and constants for the restriction site scanner.
package rss_pkg;

    localparam int NUM_ENZYMES   = 4;
    localparam int SLOT_COUNT    = 4;
    localparam int SLOT_W        = 2;
    localparam int WINDOW_BASES  = 16;
    localparam int NIBBLE_W      = 4;
    localparam int WIN_W         = WINDOW_BASES * NIBBLE_W;
    localparam int POS_W         = 32;
    localparam int LEN_W         = 5;
    localparam int TAIL_STEPS    = 15;
    localparam int TAIL_CNT_W    = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BASE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_END    = 4'd8;

    localparam logic [LEN_W-1:0] LENGTH_RESET = 5'd31;

    typedef logic [SLOT_COUNT-1:0][WIN_W-1:0] rss_pattern_arr_t;
    typedef logic [SLOT_COUNT-1:0][LEN_W-1:0] rss_length_arr_t;

    // One window to be tested by the back end
    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [POS_W-1:0] position;
        logic             test_en;
        logic             final_task;
    } rss_task_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } rss_qstat_t;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_TAIL
    } rss_front_state_t;

endpackage

/* src/rss_front.sv */
// Front end: takes bases, keeps the window and position, queues window tests.
module rss_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [3:0]             base_code,
    input  logic                   last_base,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rss_pkg::rss_qstat_t    qstat,
    output logic                   push,
    output rss_pkg::rss_task_t     push_task
);
    import rss_pkg::*;

    rss_front_state_t        state_reg, state_next;
    logic [WIN_W-1:0]        window_reg, window_next;
    logic [POS_W-1:0]        seen_reg, seen_next;
    logic [TAIL_CNT_W-1:0]   tail_cnt_reg, tail_cnt_next;

    logic [WIN_W-1:0]        win_shift;
    logic [POS_W-1:0]        seen_inc;
    logic [POS_W:0]          tail_sum;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FRONT_IDLE;
            window_reg   <= '0;
            seen_reg     <= '0;
            tail_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            seen_reg     <= seen_next;
            tail_cnt_reg <= tail_cnt_next;
        end
    end

    // Saturating count and tail position sum
    assign seen_inc = (seen_reg == {POS_W{1'b1}}) ? seen_reg : seen_reg + 1'b1;
    assign tail_sum = {1'b0, seen_reg} + (POS_W + 1)'(tail_cnt_reg);

    // Next state, queue pushes
    always_comb begin
        state_next    = state_reg;
        window_next   = window_reg;
        seen_next     = seen_reg;
        tail_cnt_next = tail_cnt_reg;
        push          = 1'b0;
        push_task     = '0;
        in_ready      = 1'b0;
        win_shift     = '0;
        case (state_reg)
            FRONT_IDLE: begin
                in_ready  = !qstat.full;
                win_shift = {window_reg[WIN_W-NIBBLE_W-1:0], base_code};
                if (in_valid && !qstat.full) begin
                    push                 = 1'b1;
                    push_task.window     = win_shift;
                    push_task.position   = seen_inc - POS_W'(WINDOW_BASES);
                    push_task.test_en    = (seen_inc >= POS_W'(WINDOW_BASES));
                    push_task.final_task = !last_base;
                    window_next          = win_shift;
                    seen_next            = seen_inc;
                    if (last_base) begin
                        state_next    = FRONT_TAIL;
                        tail_cnt_next = '0;
                    end
                end
            end
            FRONT_TAIL: begin
                win_shift = {window_reg[WIN_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                if (!qstat.full) begin
                    push                 = 1'b1;
                    push_task.window     = win_shift;
                    push_task.position   = POS_W'(tail_sum - (POS_W + 1)'(TAIL_STEPS));
                    push_task.test_en    = (tail_sum >= (POS_W + 1)'(TAIL_STEPS));
                    push_task.final_task = (tail_cnt_reg == TAIL_CNT_W'(TAIL_STEPS - 1));
                    window_next          = win_shift;
                    tail_cnt_next        = tail_cnt_reg + 1'b1;
                    // Drop the run state after the last tail window
                    if (tail_cnt_reg == TAIL_CNT_W'(TAIL_STEPS - 1)) begin
                        state_next  = FRONT_IDLE;
                        window_next = '0;
                        seen_next   = '0;
                    end
                end
            end
            default: begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

endmodule

/* src/rss_queue.sv */
// Short queue of window tests between the front and back ends.
module rss_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rss_pkg::rss_task_t  push_task,
    input  logic                pop,
    output rss_pkg::rss_task_t  head_task,
    output rss_pkg::rss_qstat_t qstat
);
    import rss_pkg::*;

    rss_task_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]       count_reg, count_next;
    logic                    do_push, do_pop;

    assign qstat.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_task   = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

/* src/rss_back.sv */
// Back end: matches queued windows against the slots and issues hits.
module rss_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rss_pkg::rss_pattern_arr_t pattern,
    input  rss_pkg::rss_length_arr_t  length,
    input  rss_pkg::rss_task_t        head_task,
    input  rss_pkg::rss_qstat_t       qstat,
    output logic                      pop,
    output logic                      hit_valid,
    input  logic                      hit_ready,
    output logic [1:0]                hit_enzyme,
    output logic [31:0]               hit_position,
    output logic                      hit_last
);
    import rss_pkg::*;

    logic                    busy_reg, busy_next;
    logic [SLOT_COUNT-1:0]   mask_reg, mask_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    final_reg, final_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [POS_W-1:0]        pend_pos_reg, pend_pos_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]       out_idx_reg, out_idx_next;
    logic [POS_W-1:0]        out_pos_reg, out_pos_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic                    finishing;
    logic [SLOT_COUNT-1:0]   head_match;
    logic [SLOT_W-1:0]       low_idx;

    // Count window nibbles that share a bit with the pattern
    function automatic logic [LEN_W-1:0] count_nibbles(input logic [WIN_W-1:0] m);
        logic [LEN_W-1:0] c;
        c = '0;
        for (int j = 0; j < WINDOW_BASES; j++) begin
            c = c + LEN_W'(|m[j*NIBBLE_W +: NIBBLE_W]);
        end
        return c;
    endfunction

    // Match vector of the queue head
    always_comb begin
        head_match = '0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (k < NUM_ENZYMES) begin
                head_match[k] = head_task.test_en &&
                    (count_nibbles(head_task.window & pattern[k]) == length[k]);
            end
        end
    end

    // Lowest pending slot
    always_comb begin
        low_idx = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                low_idx = SLOT_W'(k);
            end
        end
    end

    assign out_free  = !out_valid_reg || hit_ready;
    assign finishing = busy_reg && (mask_reg == '0) &&
                       (!(final_reg && pend_valid_reg) || out_free);

    // Issue hits one behind so the last of each request gets its flag
    always_comb begin
        busy_next       = busy_reg;
        mask_next       = mask_reg;
        pos_next        = pos_reg;
        final_next      = final_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_pos_next   = pend_pos_reg;
        out_valid_next  = out_valid_reg;
        out_idx_next    = out_idx_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;

        if (out_valid_reg && hit_ready) begin
            out_valid_next = 1'b0;
        end

        if (busy_reg && (mask_reg != '0)) begin
            if (!pend_valid_reg || out_free) begin
                if (pend_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = pend_idx_reg;
                    out_pos_next   = pend_pos_reg;
                    out_last_next  = 1'b0;
                end
                pend_valid_next    = 1'b1;
                pend_idx_next      = low_idx;
                pend_pos_next      = pos_reg;
                mask_next[low_idx] = 1'b0;
            end
        end else if (finishing) begin
            // Flush the held hit as the last of its request
            if (final_reg && pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_idx_next    = pend_idx_reg;
                out_pos_next    = pend_pos_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            busy_next = 1'b0;
        end

        // Load the next window test
        if ((!busy_reg || finishing) && !qstat.empty) begin
            pop        = 1'b1;
            busy_next  = 1'b1;
            mask_next  = head_match;
            pos_next   = head_task.position;
            final_next = head_task.final_task;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            mask_reg       <= '0;
            final_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            mask_reg       <= mask_next;
            final_reg      <= final_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        pend_idx_reg <= pend_idx_next;
        pend_pos_reg <= pend_pos_next;
        out_idx_reg  <= out_idx_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign hit_valid    = out_valid_reg;
    assign hit_enzyme   = out_idx_reg;
    assign hit_position = out_pos_reg;
    assign hit_last     = out_last_reg;

`ifndef ASSERT_OFF
    a_pop_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!busy_reg || (mask_reg == '0)))
        else $error("window test loaded while hits remain");

    a_mask_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (mask_reg == '0))
        else $error("match bits left with no active test");

    a_final_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (finishing && final_reg && !pop) |=> !pend_valid_reg)
        else $error("held hit survived the end of its request");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || hit_ready) && out_valid_next && out_last_next
        |-> (busy_reg && final_reg && (mask_reg == '0)))
        else $error("last flag set outside a final flush");
`endif

endmodule

/* src/restriction_site_scanner_core.sv */
// Top level: configuration registers, stream ports, front, queue and back.
// A window test enters the queue when its base or tail step is accepted; a hit reaches
// m_axis through the match mask, the held hit and the output register, once it is known
// whether it is the last hit of its request. Input takes one base per cycle while the
// queue has room; a last base keeps s_axis_tready low while its tail windows are queued.
// The back end tests one window at a time and issues its hits before it loads the next.
// Reset: synchronous, active low; clears window, count, queue and control,
// sets every pattern to 0 and every length to 31 (slots off).
module restriction_site_scanner_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] base_code, [7:4] zero
    input  logic        s_axis_tlast,   // last_base
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [1:0] enzyme_index, [33:2] site_position, [39:34] zero
    output logic        m_axis_tlast,   // end_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import rss_pkg::*;

    rss_pattern_arr_t   pattern_reg, pattern_next;
    rss_length_arr_t    length_reg, length_next;

    rss_qstat_t         qstat;
    rss_task_t          push_task, head_task;
    logic               push, pop;
    logic [1:0]         hit_enzyme;
    logic [31:0]        hit_position;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        if (cfg_valid) begin
            if (cfg_index < CFG_LENGTH_BASE) begin
                pattern_next[SLOT_W'(cfg_index - CFG_PATTERN_BASE)] = cfg_data;
            end else if (cfg_index < CFG_INDEX_END) begin
                length_next[SLOT_W'(cfg_index - CFG_LENGTH_BASE)] = cfg_data[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= {SLOT_COUNT{LENGTH_RESET}};
        end else begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
        end
    end

    rss_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .base_code (s_axis_tdata[3:0]),
        .last_base (s_axis_tlast),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .qstat     (qstat),
        .push      (push),
        .push_task (push_task)
    );

    rss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_task (push_task),
        .pop       (pop),
        .head_task (head_task),
        .qstat     (qstat)
    );

    rss_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pattern      (pattern_reg),
        .length       (length_reg),
        .head_task    (head_task),
        .qstat        (qstat),
        .pop          (pop),
        .hit_valid    (m_axis_tvalid),
        .hit_ready    (m_axis_tready),
        .hit_enzyme   (hit_enzyme),
        .hit_position (hit_position),
        .hit_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, hit_position, hit_enzyme};

endmodule

/* sim/tb_top.sv */
// Testbench for restriction_site_scanner_core: streams bases, programs slots, checks hits.
module tb_top;
    import rss_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;

    localparam logic [NIBBLE_W-1:0] BASE_NONE = 4'b0000;
    localparam logic [NIBBLE_W-1:0] BASE_A    = 4'b0001;
    localparam logic [NIBBLE_W-1:0] BASE_C    = 4'b0010;
    localparam logic [NIBBLE_W-1:0] BASE_G    = 4'b0100;
    localparam logic [NIBBLE_W-1:0] BASE_T    = 4'b1000;
    localparam logic [NIBBLE_W-1:0] BASE_ANY  = 4'b1111;

    // GAATTC, oldest base in the top nibble
    localparam logic [WIN_W-1:0] ECORI_SITE = 64'h4118_8200_0000_0000;

    typedef struct packed {
        logic [SLOT_W-1:0] enzyme;
        logic [POS_W-1:0]  position;
        logic              end_of_run;
    } site_hit_t;

    // Tracks slot settings and window state, and holds the hits still owed by the block
    class hit_tracker;
        logic [WIN_W-1:0] pattern [SLOT_COUNT];
        logic [LEN_W-1:0] needed_len [SLOT_COUNT];
        logic [WIN_W-1:0] window;
        logic [POS_W-1:0] bases_in;
        site_hit_t        pending_hits [$];
        site_hit_t        batch [$];
        int               mismatches;

        function new();
            for (int k = 0; k < SLOT_COUNT; k++) begin
                pattern[k]    = '0;
                needed_len[k] = LENGTH_RESET;
            end
            window     = '0;
            bases_in   = '0;
            mismatches = 0;
        endfunction

        // Apply one register write; indexes past the length bank are dropped
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx < CFG_LENGTH_BASE)
                pattern[idx - CFG_PATTERN_BASE] = val;
            else if (idx < CFG_INDEX_END)
                needed_len[idx - CFG_LENGTH_BASE] = val[LEN_W-1:0];
        endfunction

        // Test every active slot against one window, lowest slot first
        function void test_window(logic [WIN_W-1:0] win, longint unsigned pos);
            logic [WIN_W-1:0] masked;
            int               overlap;
            site_hit_t        h;
            for (int k = 0; k < NUM_ENZYMES; k++) begin
                masked  = win & pattern[k];
                overlap = 0;
                for (int j = 0; j < WINDOW_BASES; j++)
                    if (masked[NIBBLE_W*j +: NIBBLE_W] != '0) overlap++;
                if (overlap == needed_len[k]) begin
                    h.enzyme     = SLOT_W'(k);
                    h.position   = POS_W'(pos);
                    h.end_of_run = 1'b0;
                    batch.push_back(h);
                end
            end
        endfunction

        // Shift in an accepted base, flush the tail on a last base, queue the hits
        function void take_base(logic [NIBBLE_W-1:0] code, logic last);
            logic [WIN_W-1:0] tail;
            longint unsigned  seen;
            batch.delete();
            window = {window[WIN_W-NIBBLE_W-1:0], code};
            if (bases_in != '1) bases_in++;
            seen = bases_in;
            if (seen >= WINDOW_BASES) test_window(window, seen - WINDOW_BASES);
            if (last) begin
                tail = window;
                for (int t = 0; t < TAIL_STEPS; t++) begin
                    tail = tail << NIBBLE_W;
                    if (seen + t >= TAIL_STEPS) test_window(tail, seen + t - TAIL_STEPS);
                end
                window   = '0;
                bases_in = '0;
            end
            if (batch.size() > 0) batch[batch.size()-1].end_of_run = 1'b1;
            foreach (batch[i]) pending_hits.push_back(batch[i]);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one delivered hit with the oldest one owed
        task match_hit(site_hit_t got);
            site_hit_t want;
            if (pending_hits.size() == 0) begin
                report_mismatch($sformatf("unexpected hit enzyme %0d position %0d last %0b",
                                          got.enzyme, got.position, got.end_of_run));
                return;
            end
            want = pending_hits.pop_front();
            if (got.enzyme != want.enzyme)
                report_mismatch($sformatf("enzyme_index got %0d want %0d",
                                          got.enzyme, want.enzyme));
            if (got.position != want.position)
                report_mismatch($sformatf("site_position got %0d want %0d",
                                          got.position, want.position));
            if (got.end_of_run != want.end_of_run)
                report_mismatch($sformatf("end_of_run got %0b want %0b at position %0d",
                                          got.end_of_run, want.end_of_run, want.position));
        endtask
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [3:0] base_code, [7:4] zero
    logic        s_axis_tlast  = 1'b0;  // last_base
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [1:0] enzyme_index, [33:2] site_position, [39:34] zero
    logic        m_axis_tlast;          // end_of_run
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index     = '0;
    logic [63:0] cfg_data      = '0;

    hit_tracker ledger = new();

    bit idle_on           = 1'b1;
    int long_holds_asked  = 0;
    int long_holds_done   = 0;
    int hold_left         = 0;
    int quiet_cycles      = 0;

    logic [NIBBLE_W-1:0] site_bases [SLOT_COUNT][WINDOW_BASES];
    int                  site_size  [SLOT_COUNT];

    restriction_site_scanner_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Take hits and pace the receiver: short random holds, one long hold on request
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            ledger.match_hit('{enzyme: m_axis_tdata[1:0], position: m_axis_tdata[33:2],
                               end_of_run: m_axis_tlast});
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (long_holds_done < long_holds_asked) begin
            long_holds_done++;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Stop the run when no request of any channel completes for too long
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one base, with an optional idle burst first; leave tvalid high
    task automatic send_base(logic [NIBBLE_W-1:0] code, logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_axis_tdata  <= {4'b0000, code};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        ledger.take_base(code, last);
    endtask

    // Issue one register write request; the caller drops cfg_valid after a batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        ledger.set_reg(idx, val);
    endtask

    // Drop the input, wait for every owed hit, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [NIBBLE_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return BASE_A;
            1:       return BASE_C;
            2:       return BASE_G;
            default: return BASE_T;
        endcase
    endfunction

    // Mostly clean bases, now and then any code including none or ambiguous
    function automatic logic [NIBBLE_W-1:0] noisy_base();
        if ($urandom_range(0, 7) == 0) return NIBBLE_W'($urandom);
        return pick_base();
    endfunction

    // Build a random site per slot and program it; some slots get odd lengths
    task automatic program_random_slots();
        logic [WIN_W-1:0]      pat;
        logic [CFG_DATA_W-1:0] len_word;
        logic [NIBBLE_W-1:0]   base;
        int                    len;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            len = $urandom_range(1, WINDOW_BASES);
            pat = '0;
            for (int j = 0; j < len; j++) begin
                base = pick_base();
                site_bases[k][j] = base;
                // widen some positions to ambiguity sets that still hold the base
                if ($urandom_range(0, 3) == 0) base = base | NIBBLE_W'($urandom);
                pat[WIN_W-1-NIBBLE_W*j -: NIBBLE_W] = base;
            end
            site_size[k] = len;
            len_word = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: begin
                    pat = {$urandom, $urandom};
                    len_word[LEN_W-1:0] = LEN_W'($urandom_range(0, 31));
                end
                1: len_word[LEN_W-1:0] = $urandom_range(0, 1) ? 5'd17 :
                                          LEN_W'($urandom_range(18, 31));
                2: len_word[LEN_W-1:0] = '0;
                default: len_word[LEN_W-1:0] = LEN_W'(len);
            endcase
            write_reg(CFG_IDX_W'(CFG_PATTERN_BASE + k), pat);
            write_reg(CFG_IDX_W'(CFG_LENGTH_BASE + k), len_word);
        end
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_INDEX_END, 15)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // Random sequences with planted sites; some short, each closed by a last base
    task automatic run_random(int n_items);
        int sent = 0;
        int seq_len;
        int j;
        int k;
        while (sent < n_items) begin
            seq_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15) :
                                                     $urandom_range(16, 40);
            j = 0;
            while (j < seq_len) begin
                if ($urandom_range(0, 2) == 0) begin
                    k = $urandom_range(0, SLOT_COUNT - 1);
                    for (int i = 0; i < site_size[k] && j < seq_len; i++) begin
                        send_base(site_bases[k][i], j == seq_len - 1);
                        j++;
                    end
                end else begin
                    send_base(noisy_base(), j == seq_len - 1);
                    j++;
                end
            end
            sent += seq_len;
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // all slots are off after reset: nothing may come out
        send_base(BASE_A, 1'b0);
        send_base(BASE_ANY, 1'b0);
        send_base(BASE_NONE, 1'b1);
        settle();

        // one site, an all-covered slot, an all-empty slot, and a slot left off
        write_reg(CFG_PATTERN_BASE + 4'd0, ECORI_SITE);
        write_reg(CFG_PATTERN_BASE + 4'd1, '1);
        write_reg(CFG_PATTERN_BASE + 4'd2, '1);
        write_reg(CFG_PATTERN_BASE + 4'd3, {$urandom, $urandom});
        write_reg(CFG_LENGTH_BASE + 4'd0, 64'd6);
        write_reg(CFG_LENGTH_BASE + 4'd1, 64'd16);
        write_reg(CFG_LENGTH_BASE + 4'd2, 64'd0);
        write_reg(CFG_LENGTH_BASE + 4'd3, 64'd31);
        write_reg(CFG_INDEX_END, '1);
        write_reg(4'd15, '1);
        cfg_valid <= 1'b0;

        // single-base sequences: only the last tail window has a valid position
        send_base(BASE_T, 1'b1);
        send_base(BASE_NONE, 1'b1);
        // full window of ambiguous bases ending in the site, flushed at once
        repeat (10) send_base(BASE_ANY, 1'b0);
        send_base(BASE_G, 1'b0);
        send_base(BASE_A, 1'b0);
        send_base(BASE_A, 1'b0);
        send_base(BASE_T, 1'b0);
        send_base(BASE_T, 1'b0);
        send_base(BASE_C, 1'b1);
        settle();

        // every slot matches every window: most hits per base while the receiver holds off
        for (int k = 0; k < SLOT_COUNT; k++) begin
            write_reg(CFG_IDX_W'(CFG_PATTERN_BASE + k), '0);
            write_reg(CFG_IDX_W'(CFG_LENGTH_BASE + k), '0);
        end
        cfg_valid <= 1'b0;
        long_holds_asked++;
        for (int r = 0; r < 2; r++)
            for (int i = 0; i < WINDOW_BASES; i++)
                send_base(NIBBLE_W'($urandom), i == WINDOW_BASES - 1);
        settle();

        // random phases; the last one runs without idling
        for (int p = 0; p < 3; p++) begin
            idle_on = (p < 2);
            program_random_slots();
            run_random(25);
            settle();
        end

        if (ledger.mismatches == 0 && ledger.pending_hits.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
